### hdl/gbn_pkg.sv
// Shared constants for the go-back-n sender: field widths and request/timer codes.
`default_nettype none

package gbn_pkg;

    localparam int REQ_W  = 2;
    localparam int WIN_W  = 3;
    localparam int TAG_W  = 3;
    localparam int TCMD_W = 2;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_SEND    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACK     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

    // timer commands
    localparam logic [TCMD_W-1:0] TMR_NONE    = 2'd0;
    localparam logic [TCMD_W-1:0] TMR_START   = 2'd1;
    localparam logic [TCMD_W-1:0] TMR_STOP    = 2'd2;
    localparam logic [TCMD_W-1:0] TMR_RESTART = 2'd3;

    // most packets replayed by one timeout
    localparam logic [WIN_W-1:0] MAX_REPLAY = 3'd7;

    // window size after reset
    localparam logic [WIN_W-1:0] WIN_RESET = 3'd4;

endpackage

`default_nettype wire

### hdl/gbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gbn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/go_back_n_sender.sv
// Go-back-N ARQ sender: window control, timer commands and replay from a payload RAM.
// A result is held in the output register and is offered in the cycle after its input transfer.
// Send, ack and unknown requests give one result; one item per cycle when m_tready holds.
// A timeout with N packets outstanding gives N results, the first via the payload RAM read
// register and then the output register, then one per cycle while m_tready holds (one packet per read).
// Reset (rst_n low, async): base = next_seq = 1, timer tag 0, window 4; RAM not cleared.
`default_nettype none

module go_back_n_sender #(
    parameter int SEQ_MODULUS   = 8,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic clk,
    input  logic rst_n,

    // configuration: window_size
    input  logic                      cfg_we,
    input  logic [gbn_pkg::WIN_W-1:0] cfg_wdata,

    // request stream
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // tdata, low bit up: payload, ack_num, checksum_ok, expired_tag, zero pad
    input  logic [((PAYLOAD_WIDTH+7+7)/8)*8-1:0]       s_tdata,
    // tuser: req_type
    input  logic [gbn_pkg::REQ_W-1:0]                  s_tuser,

    // result stream
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // tdata, low bit up: accepted, pkt_seq, pkt_payload, timer_cmd, timer_tag, zero pad
    output logic [((PAYLOAD_WIDTH+9+7)/8)*8-1:0]       m_tdata,
    // tuser: pkt_valid
    output logic                                       m_tuser,
    // tlast: last result of a request
    output logic                                       m_tlast
);

    import gbn_pkg::*;

    localparam int PW     = PAYLOAD_WIDTH;
    localparam int SEQ_W  = $clog2(SEQ_MODULUS);
    // compare width wide enough for sequence numbers, 3-bit fields and the modulus
    localparam int AW     = ((SEQ_W > 3) ? SEQ_W : 3) + 1;
    localparam int OUT_TW = ((PW + 9 + 7) / 8) * 8;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_OUT  = 1'b1;   // timeout replay, one packet per cycle while m_tready holds

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] a);
        seq_inc = (a == SEQ_W'(SEQ_MODULUS - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] from,
                                                  input logic [SEQ_W-1:0] to);
        logic [SEQ_W:0] d;
        d = {1'b0, to} - {1'b0, from};
        if (d[SEQ_W])
        begin
            d = d + (SEQ_W+1)'(SEQ_MODULUS);
        end
        seq_dist = d[SEQ_W-1:0];
    endfunction

    // input fields
    logic [PW-1:0]     in_payload;
    logic [2:0]        in_ack;
    logic              in_ck;
    logic [TAG_W-1:0]  in_tag;

    assign in_payload = s_tdata[PW-1:0];
    assign in_ack     = s_tdata[PW+2:PW];
    assign in_ck      = s_tdata[PW+3];
    assign in_tag     = s_tdata[PW+6:PW+4];

    // control state
    logic              state_reg, state_next;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic [SEQ_W-1:0]  base_reg, base_next;
    logic [SEQ_W-1:0]  nseq_reg, nseq_next;
    logic [TAG_W-1:0]  rtag_reg, rtag_next;
    logic [SEQ_W-1:0]  cur_reg, cur_next;      // replay sequence number
    logic [WIN_W-1:0]  rem_reg, rem_next;      // replay packets left
    logic              first_reg, first_next;  // first replay result carries the timer

    // output register
    logic              mv_reg, mv_next;
    logic              o_acc_reg, o_acc_next;
    logic              o_pv_reg, o_pv_next;
    logic [2:0]        o_seq_reg, o_seq_next;
    logic [PW-1:0]     o_pay_reg, o_pay_next;
    logic [TCMD_W-1:0] o_tcmd_reg, o_tcmd_next;
    logic [TAG_W-1:0]  o_ttag_reg, o_ttag_next;
    logic              o_last_reg, o_last_next;

    // payload RAM ports
    logic              ram_we;
    logic              ram_re;
    logic [SEQ_W-1:0]  ram_raddr;
    logic [PW-1:0]     ram_rdata;

    logic              out_free;
    logic              in_xfer;
    logic [SEQ_W-1:0]  outstanding;
    logic [WIN_W-1:0]  eff_win;
    logic              win_full;
    logic [AW-1:0]     ack_w;
    logic [SEQ_W-1:0]  ack_mod;
    logic              ack_ok;
    logic [SEQ_W-1:0]  ack_base;

    gbn_ram #(
        .WIDTH (PW),
        .DEPTH (SEQ_MODULUS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (nseq_reg),
        .wdata (in_payload),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // the output register takes a new result when empty or drained this cycle
    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_xfer  = s_tvalid && s_tready;

    // window bookkeeping
    assign outstanding = seq_dist(base_reg, nseq_reg);
    assign eff_win     = (AW'(win_reg) > AW'(SEQ_MODULUS - 1)) ? WIN_W'(SEQ_MODULUS - 1)
                                                               : win_reg;
    assign win_full    = AW'(outstanding) >= AW'(eff_win);

    // ack number mod the sequence space; a 3-bit value stays below twice a modulus of 4 or more
    assign ack_w    = (AW'(in_ack) >= AW'(SEQ_MODULUS)) ? AW'(in_ack) - AW'(SEQ_MODULUS)
                                                        : AW'(in_ack);
    assign ack_mod  = SEQ_W'(ack_w);
    assign ack_ok   = in_ck && (seq_dist(base_reg, ack_mod) < outstanding);
    assign ack_base = seq_inc(ack_mod);

    assign ram_we = in_xfer && (s_tuser == REQ_SEND) && !win_full;

    always_comb
    begin
        state_next  = state_reg;
        win_next    = win_reg;
        base_next   = base_reg;
        nseq_next   = nseq_reg;
        rtag_next   = rtag_reg;
        cur_next    = cur_reg;
        rem_next    = rem_reg;
        first_next  = first_reg;
        ram_re      = 1'b0;
        ram_raddr   = base_reg;

        mv_next     = mv_reg && !m_tready;
        o_acc_next  = o_acc_reg;
        o_pv_next   = o_pv_reg;
        o_seq_next  = o_seq_reg;
        o_pay_next  = o_pay_reg;
        o_tcmd_next = o_tcmd_reg;
        o_ttag_next = o_ttag_reg;
        o_last_next = o_last_reg;

        if (cfg_we)
        begin
            win_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    // default result: all zero, last set
                    mv_next     = 1'b1;
                    o_acc_next  = 1'b0;
                    o_pv_next   = 1'b0;
                    o_seq_next  = '0;
                    o_pay_next  = '0;
                    o_tcmd_next = TMR_NONE;
                    o_ttag_next = '0;
                    o_last_next = 1'b1;

                    case (s_tuser)
                        REQ_SEND:
                        begin
                            if (!win_full)
                            begin
                                o_acc_next = 1'b1;
                                o_pv_next  = 1'b1;
                                o_seq_next = 3'(nseq_reg);
                                o_pay_next = in_payload;
                                nseq_next  = seq_inc(nseq_reg);
                                if (outstanding == '0)
                                begin
                                    rtag_next   = TAG_W'(base_reg);
                                    o_tcmd_next = TMR_START;
                                    o_ttag_next = TAG_W'(base_reg);
                                end
                            end
                        end
                        REQ_ACK:
                        begin
                            if (ack_ok)
                            begin
                                base_next = ack_base;
                                if (ack_base == nseq_reg)
                                begin
                                    o_tcmd_next = TMR_STOP;
                                    o_ttag_next = rtag_reg;
                                end
                                else
                                begin
                                    rtag_next   = TAG_W'(ack_base);
                                    o_tcmd_next = TMR_RESTART;
                                    o_ttag_next = TAG_W'(ack_base);
                                end
                            end
                        end
                        REQ_TIMEOUT:
                        begin
                            if (outstanding == '0)
                            begin
                                o_tcmd_next = TMR_STOP;
                                o_ttag_next = in_tag;
                            end
                            else
                            begin
                                // nothing emitted now; replay starts with the RAM read
                                mv_next    = 1'b0;
                                rtag_next  = in_tag;
                                ram_re     = 1'b1;
                                ram_raddr  = base_reg;
                                cur_next   = base_reg;
                                rem_next   = (AW'(outstanding) > AW'(MAX_REPLAY))
                                             ? MAX_REPLAY : WIN_W'(outstanding);
                                first_next = 1'b1;
                                state_next = ST_OUT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    mv_next     = 1'b1;
                    o_acc_next  = 1'b0;
                    o_pv_next   = 1'b1;
                    o_seq_next  = 3'(cur_reg);
                    o_pay_next  = ram_rdata;
                    o_tcmd_next = first_reg ? TMR_RESTART : TMR_NONE;
                    o_ttag_next = first_reg ? rtag_reg : '0;
                    o_last_next = (rem_reg == WIN_W'(1));
                    first_next  = 1'b0;
                    cur_next    = seq_inc(cur_reg);
                    rem_next    = rem_reg - 1'b1;
                    if (rem_reg == WIN_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = seq_inc(cur_reg);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            win_reg   <= WIN_RESET;
            base_reg  <= SEQ_W'(1);
            nseq_reg  <= SEQ_W'(1);
            rtag_reg  <= '0;
            cur_reg   <= '0;
            rem_reg   <= '0;
            first_reg <= 1'b0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            win_reg   <= win_next;
            base_reg  <= base_next;
            nseq_reg  <= nseq_next;
            rtag_reg  <= rtag_next;
            cur_reg   <= cur_next;
            rem_reg   <= rem_next;
            first_reg <= first_next;
            mv_reg    <= mv_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        o_acc_reg  <= o_acc_next;
        o_pv_reg   <= o_pv_next;
        o_seq_reg  <= o_seq_next;
        o_pay_reg  <= o_pay_next;
        o_tcmd_reg <= o_tcmd_next;
        o_ttag_reg <= o_ttag_next;
        o_last_reg <= o_last_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = o_pv_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = OUT_TW'({o_ttag_reg, o_tcmd_reg, o_pay_reg, o_seq_reg, o_acc_reg});

    // replay only runs with packets left to send
    a_replay_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (rem_reg != '0))
        else $error("replay with no packets left");

    // the last replayed packet returns the sender to idle
    a_replay_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free && rem_reg == WIN_W'(1)) |=> (state_reg == ST_IDLE))
        else $error("replay did not end after its last packet");

    // the payload RAM is never written while a replay reads it
    a_no_write_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("payload write during replay");

    // an accepted send always carries its packet
    a_accept_has_pkt: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && o_acc_reg) |-> (o_pv_reg && o_last_reg))
        else $error("accepted send without packet");

    // a send taken into the window advances next_seq by one
    a_send_advances: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (nseq_reg == seq_inc($past(nseq_reg))))
        else $error("next_seq did not advance after a send");

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking stream testbench for the go-back-n sender: window, ack, timeout and replay.
`timescale 1ns / 100ps

module tb;
    import gbn_pkg::*;

    localparam int SEQ_MOD      = 8;
    localparam int PAY_W        = 64;
    localparam int S_DATA_W     = ((PAY_W + 7 + 7) / 8) * 8;
    localparam int M_DATA_W     = ((PAY_W + 9 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_CAP    = 30;
    // req_type code that the block does not know; it must answer with one empty result
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    // one request as it goes into the block
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [PAY_W-1:0] payload;
        logic [WIN_W-1:0] ack;
        logic             cok;
        logic [TAG_W-1:0] tag;
    } request_t;

    // one result as it should come out
    typedef struct packed {
        logic              accepted;
        logic              pkt_valid;
        logic [WIN_W-1:0]  seq;
        logic [PAY_W-1:0]  payload;
        logic [TCMD_W-1:0] tcmd;
        logic [TAG_W-1:0]  ttag;
        logic              last;
    } pkt_result_t;

    // ------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [WIN_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [REQ_W-1:0]    s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    go_back_n_sender #(
        .SEQ_MODULUS   (SEQ_MOD),
        .PAYLOAD_WIDTH (PAY_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // low bit up: payload, ack_num, checksum_ok, expired_tag, pad
        .s_tuser   (s_tuser),   // req_type
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // low bit up: accepted, pkt_seq, pkt_payload, timer_cmd,
                                // timer_tag, pad
        .m_tuser   (m_tuser),   // pkt_valid
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the sender state, updated on every request transfer
    // ------------------------------------------------------------------
    logic [WIN_W-1:0] win_size;
    logic [WIN_W-1:0] win_base;
    logic [WIN_W-1:0] nxt_seq;
    logic [TAG_W-1:0] run_tag;
    logic [PAY_W-1:0] pay_store [SEQ_MOD];

    request_t    pending_reqs [$];   // requests not yet handed to the driver
    pkt_result_t due_results  [$];   // results predicted but not yet seen

    request_t cur_req  = '0;         // request currently on the slave side
    bit       holding  = 1'b0;       // cur_req is being offered
    bit       took     = 1'b0;       // cur_req transferred at the last rising edge
    bit       calm     = 1'b0;       // no idling on either side
    int       in_gap   = 0;
    int       out_gap  = 0;

    int errors      = 0;
    int n_requests  = 0;
    int n_results   = 0;
    int n_taken     = 0;
    int n_replayed  = 0;
    int cycle_cnt   = 0;

    function automatic pkt_result_t empty_result();
        pkt_result_t r;
        r      = '0;
        r.last = 1'b1;
        return r;
    endfunction

    // append one predicted result
    function automatic void queue_result(input pkt_result_t r);
        due_results.insert(due_results.size(), r);
    endfunction

    // append one request for the driver
    function automatic void queue_req(input request_t rq);
        pending_reqs.insert(pending_reqs.size(), rq);
    endfunction

    // Advance the shadow state by one request and queue the results it causes.
    function automatic void sender_step(input request_t rq);
        logic [WIN_W-1:0] outst;
        logic [WIN_W-1:0] span;
        logic [WIN_W-1:0] s;
        pkt_result_t      r;
        int               i;
        outst = nxt_seq - win_base;      // 3-bit wrap is modulo 8
        r     = empty_result();
        case (rq.req)
            REQ_SEND:
            begin
                // window can never exceed SEQ_MOD-1 with a 3-bit register
                if (outst < win_size)
                begin
                    pay_store[nxt_seq] = rq.payload;
                    r.accepted  = 1'b1;
                    r.pkt_valid = 1'b1;
                    r.seq       = nxt_seq;
                    r.payload   = rq.payload;
                    if (outst == 0)
                    begin
                        run_tag = win_base;
                        r.tcmd  = TMR_START;
                        r.ttag  = win_base;
                    end
                    nxt_seq = nxt_seq + 3'd1;
                end
                queue_result(r);
            end
            REQ_ACK:
            begin
                span = rq.ack - win_base;
                // bad checksum, or ack outside the outstanding range: ignored
                if (rq.cok && span < outst)
                begin
                    win_base = rq.ack + 3'd1;
                    if (win_base == nxt_seq)
                    begin
                        r.tcmd = TMR_STOP;
                        r.ttag = run_tag;
                    end
                    else
                    begin
                        run_tag = win_base;
                        r.tcmd  = TMR_RESTART;
                        r.ttag  = win_base;
                    end
                end
                queue_result(r);
            end
            REQ_TIMEOUT:
            begin
                if (outst == 0)
                begin
                    r.tcmd = TMR_STOP;
                    r.ttag = rq.tag;
                    queue_result(r);
                end
                else
                begin
                    // go back: replay everything from the window base
                    run_tag = rq.tag;
                    for (i = 0; i < int'(outst); i++)
                    begin
                        s           = win_base + 3'(i);
                        r           = '0;
                        r.pkt_valid = 1'b1;
                        r.seq       = s;
                        r.payload   = pay_store[s];
                        r.tcmd      = (i == 0) ? TMR_RESTART : TMR_NONE;
                        r.ttag      = (i == 0) ? rq.tag : '0;
                        r.last      = (i + 1 == int'(outst));
                        queue_result(r);
                    end
                end
            end
            default:
                queue_result(r);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [PAY_W-1:0] got,
                                   input logic [PAY_W-1:0] want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("tb: mismatch at cycle %0d: %s got %h want %h", cycle_cnt, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [PAY_W-1:0] got,
                               input logic [PAY_W-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples both sides at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        pkt_result_t e;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycle_cnt);
            $display("tb: failure");
            $finish;
        end
        else if (rst_n)
        begin
            // result transfer first: it belongs to an earlier request
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (due_results.size() == 0)
                    report_mismatch("result with nothing pending", m_tdata[PAY_W-1:0], '0);
                else
                begin
                    e = due_results.pop_front();
                    check_field("accepted",  m_tdata[0],     e.accepted);
                    check_field("pkt_valid", m_tuser,        e.pkt_valid);
                    check_field("pkt_seq",   m_tdata[3:1],   e.seq);
                    check_field("payload",   m_tdata[67:4],  e.payload);
                    check_field("timer_cmd", m_tdata[69:68], e.tcmd);
                    check_field("timer_tag", m_tdata[72:70], e.ttag);
                    check_field("last",      m_tlast,        e.last);
                    check_field("pad",       m_tdata[M_DATA_W-1:73], '0);
                    if (e.accepted)
                        n_taken++;
                    if (e.pkt_valid && !e.accepted)
                        n_replayed++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                sender_step(cur_req);
                took = 1'b1;
                n_requests++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver: holds a request until transferred, idles in bursts
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (took)
            begin
                holding = 1'b0;
                took    = 1'b0;
            end
            if (!holding)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (!calm && $urandom_range(0, 9) == 0)
                    in_gap = $urandom_range(1, 15) - 1;
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    holding = 1'b1;
                end
            end
        end
        s_tvalid <= holding;
        s_tdata  <= {1'b0, cur_req.tag, cur_req.cok, cur_req.ack, cur_req.payload};
        s_tuser  <= cur_req.req;
    end

    // Result side back-pressure, also in bursts
    always @(negedge clk)
    begin : sink
        bit rdy;
        rdy = 1'b1;
        if (out_gap > 0)
        begin
            out_gap--;
            rdy = 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            out_gap = $urandom_range(1, 15) - 1;
            rdy     = 1'b0;
        end
        m_tready <= rdy && rst_n;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_req(input logic [REQ_W-1:0] req, input logic [PAY_W-1:0] pay,
                           input logic [WIN_W-1:0] ack, input logic cok,
                           input logic [TAG_W-1:0] tag);
        request_t rq;
        rq = '{req: req, payload: pay, ack: ack, cok: cok, tag: tag};
        queue_req(rq);
    endtask

    // true once the driver has nothing left and its last request went in
    function automatic bit driver_free();
        return pending_reqs.size() == 0 && (!holding || took);
    endfunction

    // every request sent and every result back: block is idle
    task automatic wait_idle();
        while (!(driver_free() && due_results.size() == 0))
        begin
            @(posedge clk);
            #0.5;
        end
    endtask

    task automatic write_window(input logic [WIN_W-1:0] v);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        win_size   = v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random request drawn against the current window state, so that most acks
    // land inside the outstanding range; the rest is noise.
    function automatic request_t random_req();
        request_t         rq;
        logic [WIN_W-1:0] outst;
        int               pick;
        outst      = nxt_seq - win_base;
        pick       = $urandom_range(0, 99);
        rq.payload = {$urandom, $urandom};
        rq.ack     = WIN_W'($urandom_range(0, 7));
        rq.cok     = 1'($urandom_range(0, 1));
        rq.tag     = TAG_W'($urandom_range(0, 7));
        if (pick < 50)
            rq.req = REQ_SEND;
        else if (pick < 78)
        begin
            rq.req = REQ_ACK;
            if (outst != 0 && $urandom_range(0, 4) != 0)
            begin
                rq.ack = win_base + 3'($urandom_range(0, int'(outst) - 1));
                rq.cok = 1'b1;
            end
        end
        else if (pick < 90)
            rq.req = REQ_TIMEOUT;
        else if (pick < 96)
        begin
            rq.req = REQ_ACK;
            rq.cok = 1'b0;
        end
        else
            rq.req = REQ_UNKNOWN;
        return rq;
    endfunction

    task automatic run_random(input int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            while (!driver_free())
            begin
                @(posedge clk);
                #0.5;
            end
            queue_req(random_req());
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    localparam logic [PAY_W-1:0] ONES = {PAY_W{1'b1}};
    localparam logic [PAY_W-1:0] PAT_A = {(PAY_W/4){4'hA}};
    localparam logic [PAY_W-1:0] PAT_5 = {(PAY_W/4){4'h5}};

    initial
    begin : main
        logic [WIN_W-1:0] phase_win [7];
        int p;
        phase_win = '{3'd0, 3'd1, 3'd5, 3'd2, 3'd7, 3'd3, 3'd6};

        // state after reset
        win_size = WIN_RESET;
        win_base = 3'd1;
        nxt_seq  = 3'd1;
        run_tag  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset window of 4: base = next = 1
        write_window(WIN_RESET);
        add_req(REQ_TIMEOUT, '0, '0, 1'b0, 3'd5);     // timeout, nothing outstanding
        add_req(REQ_ACK, '0, 3'd3, 1'b1, '0);         // ack with empty window
        add_req(REQ_SEND, '0, '0, 1'b0, '0);          // seq 1, starts timer
        add_req(REQ_SEND, ONES, 3'd7, 1'b1, 3'd7);    // seq 2
        add_req(REQ_SEND, PAT_A, '0, 1'b0, '0);       // seq 3
        add_req(REQ_SEND, PAT_5, '0, 1'b0, '0);       // seq 4, window full
        add_req(REQ_SEND, ONES, '0, 1'b0, '0);        // refused
        add_req(REQ_ACK, '0, 3'd2, 1'b0, '0);         // bad checksum
        add_req(REQ_ACK, '0, 3'd0, 1'b1, '0);         // duplicate of base-1
        add_req(REQ_ACK, '0, 3'd7, 1'b1, '0);         // beyond next_seq
        add_req(REQ_TIMEOUT, '0, '0, 1'b0, 3'd7);     // replay 1..4
        add_req(REQ_ACK, '0, 3'd2, 1'b1, '0);         // partial slide, restart
        add_req(REQ_UNKNOWN, ONES, 3'd7, 1'b1, 3'd7); // unknown request kind
        add_req(REQ_TIMEOUT, '0, '0, 1'b0, 3'd0);     // replay 3..4
        add_req(REQ_ACK, '0, 3'd4, 1'b1, '0);         // empties window, stop
        add_req(REQ_SEND, PAT_5, '0, 1'b0, '0);       // seq 5
        add_req(REQ_TIMEOUT, '0, '0, 1'b0, 3'd2);     // single replay

        // widest window: fill it, refuse one, replay all seven
        write_window(3'd7);
        repeat (7) add_req(REQ_SEND, {$urandom, $urandom}, '0, 1'b0, '0);
        add_req(REQ_TIMEOUT, '0, '0, 1'b0, 3'd6);
        wait_idle();
        add_req(REQ_ACK, '0, nxt_seq - 3'd1, 1'b1, '0); // ack everything
        run_random(40);

        for (p = 0; p < 7; p++)
        begin
            write_window(phase_win[p]);
            if (p == 6)
                calm = 1'b1;     // final stretch at full rate on both sides
            run_random(50);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (due_results.size() != 0)
            report_mismatch("results never arrived", due_results.size(), '0);

        $display("tb: %0d requests, %0d results, %0d sends taken, %0d replayed packets",
                 n_requests, n_results, n_taken, n_replayed);
        $display("tb: windows 0..7 covered, with random stalls on both streams");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
